>>> design/mht_pkg.sv
// ============================================================================
// mht_pkg: shared constants and functions for the MAC address hash table
// Operation codes, status codes, the hash constant and the mix step functions.
// ============================================================================
package mht_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  // One Jenkins mix step: x = (x - y - z) ^ shifted(z)
  function automatic logic [31:0] mix_r(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input int sh);
    mix_r = (x - y - z) ^ (z >> sh);
  endfunction

  function automatic logic [31:0] mix_l(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z, input int sh);
    mix_l = (x - y - z) ^ (z << sh);
  endfunction

endpackage

>>> design/mht_ram.sv
// ============================================================================
// mht_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module mht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/mht_front.sv
// ============================================================================
// mht_front: hash front end
// Accepts requests, runs the lookup2 mix over three pipelined stages and
// pushes the hashed request into a short queue for the back end.
// ============================================================================
module mht_front #(
  parameter int BUCKETS = 256,
  parameter int QDEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [1:0]                 op_i,
  input  logic [47:0]                key_i,
  input  logic [7:0]                 sig_i,
  output logic                       q_valid,
  input  logic                       q_pop,
  output logic [1:0]                 q_op,
  output logic [47:0]                q_key,
  output logic [7:0]                 q_sig,
  output logic [$clog2(BUCKETS)-1:0] q_bucket
);

  localparam int BW = $clog2(BUCKETS);
  localparam int QW = $clog2(QDEPTH);
  localparam int ENT = 2 + 48 + 8 + BW;

  // pipeline stage 1..3 of the mix, each with valid
  logic [2:0]  v_r, v_nxt;
  logic [31:0] a1_r, b1_r, c1_r, a2_r, b2_r, c2_r, c3_r;
  logic [57:0] pay_r [3];
  logic [QW:0] cnt_r, cnt_nxt;
  logic [QW-1:0] wp_r, rp_r;
  logic [ENT-1:0] q_r [QDEPTH];
  logic [31:0] a0, b0, t_a, t_b, t_c, u_a, u_b, u_c, w_a, w_b, w_c;
  logic [BW-1:0] bucket;
  logic push;
  logic [QW+2:0] inflight;

  // keep room for everything in the pipeline
  assign inflight  = {2'b0, cnt_r} + (QW+3)'(v_r[0]) + (QW+3)'(v_r[1]) + (QW+3)'(v_r[2]);
  assign in_tready = inflight < (QW+3)'(QDEPTH);

  always_comb begin
    a0  = key_i[31:0] + mht_pkg::GOLDEN;
    b0  = {16'b0, key_i[47:32]} + mht_pkg::GOLDEN;
    t_a = mht_pkg::mix_r(a0, b0, 32'd0, 13);
    t_b = mht_pkg::mix_l(b0, 32'd0, t_a, 8);
    t_c = (32'd0 - t_a - t_b) ^ (t_b >> 13);
    u_a = (a1_r - c1_r - b1_r) ^ (c1_r >> 12);
    u_b = (b1_r - c1_r - u_a) ^ (u_a << 16);
    u_c = (c1_r - u_a - u_b) ^ (u_b >> 5);
    w_a = (a2_r - c2_r - b2_r) ^ (c2_r >> 3);
    w_b = (b2_r - c2_r - w_a) ^ (w_a << 10);
    w_c = (c2_r - w_a - w_b) ^ (w_b >> 15);
    bucket = BW'(c3_r % BUCKETS);
  end

  assign push  = v_r[2];
  assign v_nxt = {v_r[1], v_r[0], in_tvalid && in_tready};
  assign cnt_nxt = cnt_r + (QW+1)'(push) - (QW+1)'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      cnt_r <= '0;
      wp_r  <= '0;
      rp_r  <= '0;
    end else begin
      v_r   <= v_nxt;
      cnt_r <= cnt_nxt;
      if (push) wp_r <= (wp_r == QW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == QW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a1_r <= t_a; b1_r <= t_b; c1_r <= t_c;
    a2_r <= u_a; b2_r <= u_b; c2_r <= u_c;
    c3_r <= w_c;
    pay_r[0] <= {op_i, key_i, sig_i};
    pay_r[1] <= pay_r[0];
    pay_r[2] <= pay_r[1];
    if (push) q_r[wp_r] <= {pay_r[2], bucket};
  end

  assign q_valid = cnt_r != '0;
  assign {q_op, q_key, q_sig, q_bucket} = q_r[rp_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |-> cnt_r < (QW+1)'(QDEPTH))
    else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop of empty queue");
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> inflight < (QW+3)'(QDEPTH))
    else $error("ready without room");
`endif

endmodule

>>> design/mht_back.sv
// ============================================================================
// mht_back: table engine
// Walks bucket chains in the entry store, applies the operation and
// presents one result through an output register.
// ============================================================================
module mht_back #(
  parameter int BUCKETS          = 256,
  parameter int OVERFLOW_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [1:0]                 q_op,
  input  logic [47:0]                q_key,
  input  logic [7:0]                 q_sig,
  input  logic [$clog2(BUCKETS)-1:0] q_bucket,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [51:0]                out_tdata
);

  localparam int BW = $clog2(BUCKETS);
  localparam int SS = BUCKETS + OVERFLOW_ENTRIES;
  localparam int AW = $clog2(SS);
  localparam int PW = $clog2(OVERFLOW_ENTRIES + 1);
  localparam int EW = 48 + 8 + 32 + 1 + AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [BUCKETS-1:0] head_r;
  logic [PW-1:0] fill_r;
  logic [1:0]  op_r;
  logic [47:0] key_r;
  logic [7:0]  sig_r;
  logic [AW-1:0] cur_r, fresh_r;
  logic        ov_r;
  logic [51:0] res_r;
  logic        we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [47:0] e_key;
  logic [7:0]  e_sig;
  logic [31:0] e_cnt;
  logic        e_lv;
  logic [AW-1:0] e_nxt;
  logic [8:0]  cur9;

  assign {e_key, e_sig, e_cnt, e_lv, e_nxt} = rdata;
  assign q_pop = (state_r == S_IDLE) && q_valid && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = res_r;
  assign cur9 = 9'(cur_r);

  mht_ram #(.WIDTH(EW), .DEPTH(SS)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    we = 1'b0;
    addr = cur_r;
    wdata = rdata;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_op)
            mht_pkg::OP_CLEAR: state_nxt = S_IDLE;
            mht_pkg::OP_INSERT: begin
              if (!head_r[q_bucket]) state_nxt = S_LINK;
              else if (32'(fill_r) >= OVERFLOW_ENTRIES) state_nxt = S_IDLE;
              else state_nxt = S_READ;
            end
            default: state_nxt = head_r[q_bucket] ? S_READ : S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_CHECK;
      S_CHECK: begin
        if (op_r == mht_pkg::OP_INSERT) begin
          if (e_lv && 32'(e_nxt) < SS) begin
            addr = e_nxt;
            state_nxt = S_CHECK;
          end else begin
            we = 1'b1;
            wdata = {e_key, e_sig, e_cnt, 1'b1, fresh_r};
            state_nxt = S_LINK;
          end
        end else if (e_key == key_r) begin
          if (op_r == mht_pkg::OP_UPDATE) begin
            we = 1'b1;
            wdata = {e_key, sig_r, (e_cnt == '1) ? e_cnt : e_cnt + 1'b1, e_lv, e_nxt};
          end
          state_nxt = S_DONE;
        end else if (e_lv && 32'(e_nxt) < SS) begin
          addr = e_nxt;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LINK: begin
        we = 1'b1;
        addr = fresh_r;
        wdata = {key_r, 8'd0, 32'd0, 1'b0, {AW{1'b0}}};
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      if (q_pop) begin
        op_r  <= q_op;
        key_r <= q_key;
        sig_r <= q_sig;
        cur_r <= AW'(q_bucket);
        case (q_op)
          mht_pkg::OP_CLEAR: begin
            head_r <= '0;
            fill_r <= '0;
            res_r  <= '0;
            ov_r   <= 1'b1;
          end
          mht_pkg::OP_INSERT: begin
            if (!head_r[q_bucket]) begin
              head_r[q_bucket] <= 1'b1;
              fresh_r <= AW'(q_bucket);
            end else if (32'(fill_r) >= OVERFLOW_ENTRIES) begin
              res_r <= {mht_pkg::ST_FULL, 50'd0};
              ov_r  <= 1'b1;
            end else begin
              fresh_r <= AW'(BUCKETS + 32'(fill_r));
              fill_r  <= fill_r + 1'b1;
            end
          end
          default: begin
            if (!head_r[q_bucket]) begin
              res_r <= {mht_pkg::ST_NOT_FOUND, 50'd0};
              ov_r  <= 1'b1;
            end
          end
        endcase
      end
      if (state_r == S_CHECK) begin
        cur_r <= addr;
        if (op_r != mht_pkg::OP_INSERT && state_nxt == S_DONE) begin
          ov_r <= 1'b1;
          if (e_key == key_r)
            res_r <= {mht_pkg::ST_OK,
                      (op_r == mht_pkg::OP_UPDATE) ? sig_r : e_sig,
                      (op_r == mht_pkg::OP_UPDATE && e_cnt != '1) ? e_cnt + 1'b1 : e_cnt,
                      cur9, 1'b1};
          else
            res_r <= {mht_pkg::ST_NOT_FOUND, 50'd0};
        end
      end
      if (state_r == S_LINK) begin
        res_r <= {mht_pkg::ST_OK, 8'd0, 32'd0, 9'(fresh_r), 1'b1};
        ov_r  <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= OVERFLOW_ENTRIES)
    else $error("pool fill beyond pool");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(res_r))
    else $error("result lost while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !ov_r && state_r == S_IDLE)
    else $error("pop while busy");
`endif

endmodule

>>> design/mac_address_hash_table_top.sv
// ============================================================================
// mac_address_hash_table_top: chained MAC address hash table
// Input stream of requests, output stream of one result per request.
// ============================================================================
// in_tdata: operation[1:0], mac_key[49:2], signal_level[57:50], zero to 64.
// out_tdata: found[0], entry_index[9:1], frame_count[41:10],
//   last_signal[49:42], status[51:50], zero to 56 bits.
// A request is taken when in_tvalid and in_tready are both high. The front
// end hashes it in three pipeline stages into a four-entry queue; the back
// end runs one request at a time against a single-port entry store.
// A queued request goes to the back end, which reads the bucket head, walks
// the chain one entry at a time and, for an insert or an update, writes
// the store. It takes the next request only once the last result has left
// the output register; every store access goes through the single port.
// Results wait in an output register; while out_tready is low the back end
// holds and the queue fills, then in_tready drops. Reset empties all heads
// and the pool at once; entry contents need no clearing.
module mac_address_hash_table_top #(
  parameter int BUCKETS          = 256,
  parameter int OVERFLOW_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operation, mac_key, signal_level
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // found, entry_index, frame_count, last_signal, status
);

  localparam int BW = $clog2(BUCKETS);

  logic q_valid, q_pop;
  logic [1:0] q_op;
  logic [47:0] q_key;
  logic [7:0] q_sig;
  logic [BW-1:0] q_bucket;
  logic [51:0] res;
  logic unused_in;

  assign unused_in = ^in_tdata[63:58];

  mht_front #(.BUCKETS(BUCKETS), .QDEPTH(4)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .op_i(in_tdata[1:0]), .key_i(in_tdata[49:2]), .sig_i(in_tdata[57:50]),
    .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_key(q_key),
    .q_sig(q_sig), .q_bucket(q_bucket)
  );

  mht_back #(.BUCKETS(BUCKETS), .OVERFLOW_ENTRIES(OVERFLOW_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op),
    .q_key(q_key), .q_sig(q_sig), .q_bucket(q_bucket),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(res)
  );

  assign out_tdata = {4'd0, res};

endmodule

>>> bench/mht_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// mht_checker: result predictor and scoreboard for the MAC hash table
// Watches both stream channels, keeps its own copy of the heads, the entry
// store and the pool, predicts one result per request and compares in order.
// ============================================================================
module mht_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // operation, mac_key, signal_level
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // found, entry_index, frame_count, last_signal, status
  output int          fails,
  output int          pending
);

  localparam int NBKT  = 256;
  localparam int NPOOL = 256;
  localparam int NSTORE = NBKT + NPOOL;

  typedef struct packed {
    logic        found;
    logic [8:0]  index;
    logic [31:0] count;
    logic [7:0]  level;
    logic [1:0]  status;
  } table_result_t;

  logic        head_ok [NBKT];
  logic [47:0] key_mem [NSTORE];
  logic [7:0]  level_mem [NSTORE];
  logic [31:0] count_mem [NSTORE];
  logic [9:0]  next_mem [NSTORE];
  logic        link_ok [NSTORE];
  int          pool_used;
  table_result_t results_due[$];

  function automatic int bucket_of(input logic [47:0] key);
    logic [31:0] a, b, c;
    a = key[31:0] + mht_pkg::GOLDEN;
    b = {16'd0, key[47:32]} + mht_pkg::GOLDEN;
    c = 32'd0;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return int'(c % NBKT);
  endfunction

  // first match along the chain, -1 when absent
  function automatic int chain_find(input logic [47:0] key);
    int cur;
    cur = bucket_of(key);
    if (!head_ok[cur]) return -1;
    for (int s = 0; s < NSTORE; s++) begin
      if (key_mem[cur] == key) return cur;
      if (!link_ok[cur] || next_mem[cur] >= NSTORE) return -1;
      cur = next_mem[cur];
    end
    return -1;
  endfunction

  function automatic table_result_t hit(input int idx);
    table_result_t r;
    r.found  = 1'b1;
    r.index  = idx[8:0];
    r.count  = count_mem[idx];
    r.level  = level_mem[idx];
    r.status = mht_pkg::ST_OK;
    return r;
  endfunction

  function automatic table_result_t miss(input logic [1:0] st);
    table_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic apply_request(input logic [1:0] op, input logic [47:0] key,
                               input logic [7:0] level);
    int cur, fresh, idx;
    case (op)
      mht_pkg::OP_CLEAR: begin
        for (int i = 0; i < NBKT; i++) head_ok[i] = 1'b0;
        pool_used = 0;
        results_due.push_back(miss(mht_pkg::ST_OK));
      end
      mht_pkg::OP_INSERT: begin
        cur = bucket_of(key);
        if (!head_ok[cur]) begin
          head_ok[cur] = 1'b1;
          fresh = cur;
        end else if (pool_used >= NPOOL) begin
          fresh = -1;
        end else begin
          for (int s = 0; s < NSTORE && link_ok[cur] && next_mem[cur] < NSTORE; s++)
            cur = next_mem[cur];
          fresh = NBKT + pool_used;
          pool_used++;
          next_mem[cur] = fresh[9:0];
          link_ok[cur] = 1'b1;
        end
        if (fresh < 0) begin
          results_due.push_back(miss(mht_pkg::ST_FULL));
        end else begin
          key_mem[fresh] = key;
          level_mem[fresh] = '0;
          count_mem[fresh] = '0;
          next_mem[fresh] = '0;
          link_ok[fresh] = 1'b0;
          results_due.push_back(hit(fresh));
        end
      end
      mht_pkg::OP_UPDATE: begin
        idx = chain_find(key);
        if (idx < 0) begin
          results_due.push_back(miss(mht_pkg::ST_NOT_FOUND));
        end else begin
          level_mem[idx] = level;
          if (count_mem[idx] != 32'hFFFF_FFFF) count_mem[idx]++;
          results_due.push_back(hit(idx));
        end
      end
      default: begin
        idx = chain_find(key);
        results_due.push_back(idx < 0 ? miss(mht_pkg::ST_NOT_FOUND) : hit(idx));
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
    pool_used = 0;
    for (int i = 0; i < NBKT; i++) head_ok[i] = 1'b0;
    for (int i = 0; i < NSTORE; i++) begin
      key_mem[i] = '0; level_mem[i] = '0; count_mem[i] = '0;
      next_mem[i] = '0; link_ok[i] = 1'b0;
    end
  end

  always @(posedge clk) begin
    table_result_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        apply_request(in_tdata[1:0], in_tdata[49:2], in_tdata[57:50]);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[9:1], out_tdata[41:10], out_tdata[49:42],
               out_tdata[51:50]};
        if (results_due.size() == 0) begin
          report("unexpected result", {24'd0, out_tdata[7:0]}, 32'd0);
        end else begin
          want = results_due.pop_front();
          if (got.found  != want.found)  report("found", got.found, want.found);
          if (got.index  != want.index)  report("entry_index", got.index, want.index);
          if (got.count  != want.count)  report("frame_count", got.count, want.count);
          if (got.level  != want.level)  report("last_signal", got.level, want.level);
          if (got.status != want.status) report("status", got.status, want.status);
        end
      end
      pending = results_due.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: stimulus and verdict for the MAC address hash table
// Directed requests for the corner cases, then random requests biased to
// reuse inserted keys and to fill the overflow pool, with random gaps and
// stalls on both sides and one long output stall.
// ============================================================================
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // operation, mac_key, signal_level
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // found, entry_index, frame_count, last_signal, status
  int          fails, pending;
  int          results_taken;
  int          hold_left;
  bit          long_hold_done;
  logic [47:0] known_keys[$];

  mac_address_hash_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  mht_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    hold_left = 0;
    results_taken = 0;
    long_hold_done = 1'b0;
  end

  // receiver: random wait per result, one long hold to back up the input
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_taken <= results_taken + 1;
        if (results_taken == 300 && !long_hold_done) begin
          long_hold_done <= 1'b1;
          hold_left <= 400;
        end else begin
          hold_left <= $urandom_range(0, 5);
        end
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0) ? 1'b1 : 1'b0;
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [47:0] key,
                              input logic [7:0] level);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, level, key, op};
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    if (op == mht_pkg::OP_INSERT) known_keys.push_back(key);
    if (op == mht_pkg::OP_CLEAR) known_keys.delete();
  endtask

  function automatic logic [47:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(0, 4) != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return 48'({$urandom, $urandom});
  endfunction

  initial begin
    logic [1:0] op;
    int w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(mht_pkg::OP_FIND,   48'h0, 8'h00);
    send_request(mht_pkg::OP_UPDATE, 48'hFFFF_FFFF_FFFF, 8'h7F);
    send_request(mht_pkg::OP_INSERT, 48'h0, 8'hFF);
    send_request(mht_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 8'h00);
    send_request(mht_pkg::OP_FIND,   48'h0, 8'h00);
    send_request(mht_pkg::OP_FIND,   48'hFFFF_FFFF_FFFF, 8'h00);
    send_request(mht_pkg::OP_UPDATE, 48'h0, 8'h80);
    send_request(mht_pkg::OP_UPDATE, 48'h0, 8'h7F);
    send_request(mht_pkg::OP_UPDATE, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_request(mht_pkg::OP_INSERT, 48'h0, 8'h55);          // duplicate key
    send_request(mht_pkg::OP_FIND,   48'h0, 8'h00);          // first in chain wins
    send_request(mht_pkg::OP_UPDATE, 48'h0, 8'h01);
    send_request(mht_pkg::OP_INSERT, 48'h5A5A_A5A5_0F0F, 8'hAA);
    send_request(mht_pkg::OP_FIND,   48'h5A5A_A5A5_0F0F, 8'h00);
    send_request(mht_pkg::OP_FIND,   48'h1234_5678_9ABC, 8'h00);
    send_request(mht_pkg::OP_CLEAR,  48'hFFFF_FFFF_FFFF, 8'hFF);
    send_request(mht_pkg::OP_FIND,   48'h0, 8'h00);
    send_request(mht_pkg::OP_UPDATE, 48'hFFFF_FFFF_FFFF, 8'h10);

    for (int i = 0; i < 1600; i++) begin
      w = $urandom_range(0, 99);
      if (i == 700 || i == 1200 || w == 0) op = mht_pkg::OP_CLEAR;
      else if (i < 700)
        op = (w < 85) ? mht_pkg::OP_INSERT : (w < 93 ? mht_pkg::OP_FIND : mht_pkg::OP_UPDATE);
      else
        op = (w < 40) ? mht_pkg::OP_INSERT : (w < 70 ? mht_pkg::OP_FIND : mht_pkg::OP_UPDATE);
      send_request(op, (op == mht_pkg::OP_INSERT && $urandom_range(0, 9) != 0) ?
                   48'({$urandom, $urandom}) : pick_key(), 8'($urandom));
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < 600000) begin
      @(posedge clk);
      cycles++;
    end
    $display("TIMEOUT after %0d cycles", cycles);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/mht_pkg.sv
design/mht_ram.sv
design/mht_front.sv
design/mht_back.sv
design/mac_address_hash_table_top.sv
bench/mht_checker.sv
bench/tb.sv
